FILE: rtl/pair_invariant_mass_top_assert.svh
// assertion macros shared by the pair invariant mass rtl
`ifndef PAIR_INVARIANT_MASS_TOP_ASSERT_SVH
`define PAIR_INVARIANT_MASS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PIM_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pair invariant mass check failed");
`define PIM_ASSERT_EQ(name, lhs, rhs) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) == (rhs)) \
        else $error("pair invariant mass lockstep check failed");
`else
`define PIM_ASSERT(name, prop)
`define PIM_ASSERT_EQ(name, lhs, rhs)
`endif
`endif

FILE: rtl/pim_pkg.sv
// types, widths and helper functions for the pair invariant mass block
`default_nettype none
package pim_pkg;

    localparam int COMPONENT_BITS = 24;
    localparam int MASS_W = COMPONENT_BITS - 1;
    localparam int COMP_W = COMPONENT_BITS;
    localparam int SUM_W  = COMP_W + 1;
    localparam int MSQ_W  = 2 * MASS_W;
    localparam int CSQ_W  = 2 * COMP_W;
    localparam int SSQ_W  = 2 * SUM_W;
    localparam int RAD_W  = 2 * COMP_W + 2;
    localparam int ROOT_W = COMP_W + 1;
    localparam int REM_W  = ROOT_W + 2;
    localparam int OUT_W  = 25;
    localparam int SAT_W  = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic [MASS_W-1:0]        mass_a;
        logic signed [COMP_W-1:0] px_a;
        logic signed [COMP_W-1:0] py_a;
        logic signed [COMP_W-1:0] pz_a;
        logic [MASS_W-1:0]        mass_b;
        logic signed [COMP_W-1:0] px_b;
        logic signed [COMP_W-1:0] py_b;
        logic signed [COMP_W-1:0] pz_b;
    } pair_t;

    typedef struct packed {
        logic [OUT_W-1:0] pair_mass;
        logic             clamped;
    } result_t;

    // side data carried along a square root row
    typedef struct packed {
        logic [RAD_W-1:0] p2;
        logic             clamped;
    } aux_t;

    // one square root cell's content
    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        aux_t              aux;
    } sq_t;

    function automatic logic [COMP_W-1:0] comp_mag(input logic signed [COMP_W-1:0] s);
        return s[COMP_W-1] ? COMP_W'(-s) : COMP_W'(s);
    endfunction

    function automatic logic [SUM_W-1:0] sum_mag(input logic signed [SUM_W-1:0] s);
        return s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    endfunction

    function automatic logic [OUT_W-1:0] sat_mass(input logic [ROOT_W-1:0] r);
        logic [SAT_W-1:0] w;
        w = SAT_W'(r);
        if (w > SAT_W'(OUT_MAX))
            return OUT_MAX;
        return OUT_W'(w);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pim_sqrt_cell.sv
// one digit step of a pipelined floor square root
`default_nettype none
`include "pair_invariant_mass_top_assert.svh"
module pim_sqrt_cell (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire pim_pkg::sq_t prev,
    output pim_pkg::sq_t     cur
);

    logic [pim_pkg::REM_W+1:0] part;
    logic [pim_pkg::REM_W+1:0] trial;
    pim_pkg::sq_t              cur_reg;
    pim_pkg::sq_t              cur_next;

    // bring down two radicand bits, try appending a one to the root
    always_comb
    begin
        part  = {prev.rem, prev.rad[pim_pkg::RAD_W-1 -: 2]};
        trial = (pim_pkg::REM_W + 2)'({prev.root, 2'b01});
        cur_next       = prev;
        cur_next.rad   = {prev.rad[pim_pkg::RAD_W-3:0], 2'b00};
        if (part >= trial)
        begin
            cur_next.rem  = pim_pkg::REM_W'(part - trial);
            cur_next.root = {prev.root[pim_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            cur_next.rem  = pim_pkg::REM_W'(part);
            cur_next.root = {prev.root[pim_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else if (en)
            cur_reg <= cur_next;
    end

    assign cur = cur_reg;

    // remainder never exceeds twice the partial root
    `PIM_ASSERT(a_rem_bound, cur_reg.valid |-> cur_reg.rem <= pim_pkg::REM_W'({cur_reg.root, 1'b0}))

endmodule
`default_nettype wire

FILE: rtl/pim_sqrt_row.sv
// row of square root cells, one root bit per cell
`default_nettype none
module pim_sqrt_row (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              valid,
    input  wire logic [pim_pkg::RAD_W-1:0] rad,
    input  wire pim_pkg::aux_t     aux,
    output pim_pkg::sq_t           last
);

    pim_pkg::sq_t head;
    pim_pkg::sq_t chain [pim_pkg::ROOT_W+1];

    // head of the row starts from an empty remainder and root
    always_comb
    begin
        head       = '0;
        head.valid = valid;
        head.rad   = rad;
        head.aux   = aux;
    end

    assign chain[0] = head;

    for (genvar i = 0; i < pim_pkg::ROOT_W; i++)
    begin : g_cell
        pim_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .prev (chain[i]),
            .cur  (chain[i+1])
        );
    end

    assign last = chain[pim_pkg::ROOT_W];

endmodule
`default_nettype wire

FILE: rtl/pair_invariant_mass_top.sv
// throughput: one pair word per cycle; the whole pipeline holds while a result waits
// two rows of square root cells (energies, then pair mass) set the depth, one bit per cell
// reset: asynchronous active low, clears all valid bits; the block keeps no other state
`default_nettype none
`include "pair_invariant_mass_top_assert.svh"
module pair_invariant_mass_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pair_valid,
    output logic                  pair_ready,
    input  wire pim_pkg::pair_t   pair,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output pim_pkg::result_t      result
);

    logic adv;

    // stage 1: input word
    logic           s1_valid_reg;
    pim_pkg::pair_t s1_reg;

    // stage 2: squares
    logic s2_valid_reg;
    logic [pim_pkg::MSQ_W-1:0] ma2_reg, mb2_reg;
    logic [pim_pkg::CSQ_W-1:0] xa2_reg, ya2_reg, za2_reg, xb2_reg, yb2_reg, zb2_reg;
    logic [pim_pkg::SSQ_W-1:0] sx2_reg, sy2_reg, sz2_reg;
    logic [pim_pkg::MSQ_W-1:0] ma2_next, mb2_next;
    logic [pim_pkg::CSQ_W-1:0] xa2_next, ya2_next, za2_next, xb2_next, yb2_next, zb2_next;
    logic [pim_pkg::SSQ_W-1:0] sx2_next, sy2_next, sz2_next;
    logic [pim_pkg::SUM_W-1:0] sx_mag, sy_mag, sz_mag;

    // stage 3: partial sums
    logic s3_valid_reg;
    logic [pim_pkg::RAD_W-1:0] a01_reg, a23_reg, b01_reg, b23_reg, pxy_reg, pz_reg;

    // stage 4: radicands
    logic s4_valid_reg;
    logic [pim_pkg::RAD_W-1:0] rad_a_reg, rad_b_reg, p2_reg;
    pim_pkg::aux_t aux_a, aux_b;
    pim_pkg::sq_t  ea_last, eb_last;

    // stages 5 to 7: energy sum, square, difference
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic [pim_pkg::ROOT_W-1:0] esum_reg;
    logic [pim_pkg::RAD_W-1:0]  s5_p2_reg, s6_p2_reg, e2_reg, diff_reg;
    logic                       clamp_reg;
    pim_pkg::aux_t              aux_m;
    pim_pkg::sq_t               pm_last;

    // output word
    logic             result_valid_reg;
    pim_pkg::result_t result_reg;

    // the pipeline moves whenever the output slot is free or being taken
    assign adv        = !result_valid_reg || result_ready;
    assign pair_ready = adv;

    // magnitudes and squares of components and summed components
    always_comb
    begin
        sx_mag   = pim_pkg::sum_mag(pim_pkg::SUM_W'(s1_reg.px_a) + pim_pkg::SUM_W'(s1_reg.px_b));
        sy_mag   = pim_pkg::sum_mag(pim_pkg::SUM_W'(s1_reg.py_a) + pim_pkg::SUM_W'(s1_reg.py_b));
        sz_mag   = pim_pkg::sum_mag(pim_pkg::SUM_W'(s1_reg.pz_a) + pim_pkg::SUM_W'(s1_reg.pz_b));
        ma2_next = pim_pkg::MSQ_W'(s1_reg.mass_a) * pim_pkg::MSQ_W'(s1_reg.mass_a);
        mb2_next = pim_pkg::MSQ_W'(s1_reg.mass_b) * pim_pkg::MSQ_W'(s1_reg.mass_b);
        xa2_next = pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.px_a))
                 * pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.px_a));
        ya2_next = pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.py_a))
                 * pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.py_a));
        za2_next = pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.pz_a))
                 * pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.pz_a));
        xb2_next = pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.px_b))
                 * pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.px_b));
        yb2_next = pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.py_b))
                 * pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.py_b));
        zb2_next = pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.pz_b))
                 * pim_pkg::CSQ_W'(pim_pkg::comp_mag(s1_reg.pz_b));
        sx2_next = pim_pkg::SSQ_W'(sx_mag) * pim_pkg::SSQ_W'(sx_mag);
        sy2_next = pim_pkg::SSQ_W'(sy_mag) * pim_pkg::SSQ_W'(sy_mag);
        sz2_next = pim_pkg::SSQ_W'(sz_mag) * pim_pkg::SSQ_W'(sz_mag);
    end

    // valid bits of the front and middle stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pair_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= ea_last.valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= pair;
            ma2_reg <= ma2_next;
            mb2_reg <= mb2_next;
            xa2_reg <= xa2_next;
            ya2_reg <= ya2_next;
            za2_reg <= za2_next;
            xb2_reg <= xb2_next;
            yb2_reg <= yb2_next;
            zb2_reg <= zb2_next;
            sx2_reg <= sx2_next;
            sy2_reg <= sy2_next;
            sz2_reg <= sz2_next;
            a01_reg <= pim_pkg::RAD_W'(ma2_reg) + pim_pkg::RAD_W'(xa2_reg);
            a23_reg <= pim_pkg::RAD_W'(ya2_reg) + pim_pkg::RAD_W'(za2_reg);
            b01_reg <= pim_pkg::RAD_W'(mb2_reg) + pim_pkg::RAD_W'(xb2_reg);
            b23_reg <= pim_pkg::RAD_W'(yb2_reg) + pim_pkg::RAD_W'(zb2_reg);
            pxy_reg <= pim_pkg::RAD_W'(sx2_reg) + pim_pkg::RAD_W'(sy2_reg);
            pz_reg  <= pim_pkg::RAD_W'(sz2_reg);
            rad_a_reg <= a01_reg + a23_reg;
            rad_b_reg <= b01_reg + b23_reg;
            p2_reg    <= pxy_reg + pz_reg;
        end
    end

    // energy square roots, momentum square rides along row a
    always_comb
    begin
        aux_a.p2      = p2_reg;
        aux_a.clamped = 1'b0;
        aux_b         = '0;
    end

    pim_sqrt_row u_energy_a (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .valid(s4_valid_reg),
        .rad  (rad_a_reg),
        .aux  (aux_a),
        .last (ea_last)
    );

    pim_sqrt_row u_energy_b (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .valid(s4_valid_reg),
        .rad  (rad_b_reg),
        .aux  (aux_b),
        .last (eb_last)
    );

    // energy sum, its square, then difference with clamp
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            esum_reg  <= ea_last.root + eb_last.root;
            s5_p2_reg <= ea_last.aux.p2;
            e2_reg    <= pim_pkg::RAD_W'(esum_reg) * pim_pkg::RAD_W'(esum_reg);
            s6_p2_reg <= s5_p2_reg;
            clamp_reg <= s6_p2_reg > e2_reg;
            diff_reg  <= (s6_p2_reg > e2_reg) ? '0 : e2_reg - s6_p2_reg;
        end
    end

    always_comb
    begin
        aux_m         = '0;
        aux_m.clamped = clamp_reg;
    end

    // pair mass square root
    pim_sqrt_row u_pair_mass (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .valid(s7_valid_reg),
        .rad  (diff_reg),
        .aux  (aux_m),
        .last (pm_last)
    );

    // output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= pm_last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.pair_mass <= pim_pkg::sat_mass(pm_last.root);
            result_reg.clamped   <= pm_last.aux.clamped;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PIM_ASSERT(a_clamp_zero, result_valid_reg && result_reg.clamped |-> result_reg.pair_mass == '0)
    `PIM_ASSERT(a_out_from_row, $rose(result_valid_reg) |-> $past(pm_last.valid))
    `PIM_ASSERT_EQ(a_energy_lockstep, ea_last.valid, eb_last.valid)

endmodule
`default_nettype wire

FILE: test/tb_pair_invariant_mass_top.sv
// testbench for the pair invariant mass block: random and directed pair words, local predictor
`default_nettype none
module tb_pair_invariant_mass_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 2 * (pim_pkg::COMPONENT_BITS + 1) + 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pair_valid = 1'b0;
    logic pair_ready;
    pim_pkg::pair_t pair = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    pim_pkg::result_t result;

    pim_pkg::result_t expected_masses[$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int clamp_seen = 0;
    bit sender_idle_on = 1'b1;
    bit receiver_idle_on = 1'b1;
    bit hold_receiver = 1'b0;

    pair_invariant_mass_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .pair_valid(pair_valid),
        .pair_ready(pair_ready),
        .pair(pair),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // floor square root, bitwise
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] square(input longint s);
        logic [63:0] m;
        m = (s < 0) ? -s : s;
        return m * m;
    endfunction

    // expected pair mass for one pair word
    function automatic pim_pkg::result_t predict_mass(input pim_pkg::pair_t p);
        pim_pkg::result_t r;
        longint ax, ay, az, bx, by, bz;
        logic [63:0] ma, mb, ea, eb, es, e2, p2;
        ax = p.px_a; ay = p.py_a; az = p.pz_a;
        bx = p.px_b; by = p.py_b; bz = p.pz_b;
        ma = 64'(p.mass_a);
        mb = 64'(p.mass_b);
        ea = root_floor(ma * ma + square(ax) + square(ay) + square(az));
        eb = root_floor(mb * mb + square(bx) + square(by) + square(bz));
        es = ea + eb;
        e2 = es * es;
        p2 = square(ax + bx) + square(ay + by) + square(az + bz);
        r = '0;
        if (p2 > e2)
            r.clamped = 1'b1;
        else
        begin
            e2 = root_floor(e2 - p2);
            r.pair_mass = (e2 > 64'(pim_pkg::OUT_MAX)) ? pim_pkg::OUT_MAX
                                                       : pim_pkg::OUT_W'(e2);
        end
        return r;
    endfunction

    // send one pair word, with optional idle burst first
    task automatic send_pair(input pim_pkg::pair_t p);
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            pair_valid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge clk);
        end
        pair_valid <= 1'b1;
        pair <= p;
        expected_masses.push_back(predict_mass(p));
        @(posedge clk);
        while (!pair_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain_all();
        while (pair_valid && !pair_ready)
            @(posedge clk);
        pair_valid <= 1'b0;
        while (expected_masses.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic pim_pkg::pair_t random_pair();
        pim_pkg::pair_t p;
        p.mass_a = pim_pkg::MASS_W'($urandom); p.px_a = pim_pkg::COMP_W'($urandom);
        p.py_a = pim_pkg::COMP_W'($urandom); p.pz_a = pim_pkg::COMP_W'($urandom);
        p.mass_b = pim_pkg::MASS_W'($urandom); p.px_b = pim_pkg::COMP_W'($urandom);
        p.py_b = pim_pkg::COMP_W'($urandom); p.pz_b = pim_pkg::COMP_W'($urandom);
        return p;
    endfunction

    // small magnitudes in random bits of width w
    function automatic logic [pim_pkg::COMP_W-1:0] narrow(input int w);
        logic [pim_pkg::COMP_W-1:0] v;
        v = pim_pkg::COMP_W'($urandom);
        v = v & ((24'd1 << w) - 24'd1);
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // receiver: random ready bursts, long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_receiver)
            result_ready <= 1'b0;
        else if (!receiver_idle_on)
            result_ready <= 1'b1;
        else if ($urandom_range(0, 9) == 0)
            result_ready <= 1'b0;
        else if (!result_ready && $urandom_range(0, 3) != 0)
            result_ready <= 1'b0;
        else
            result_ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        pim_pkg::result_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_masses.size() == 0)
            begin
                $error("unexpected result word pair_mass=%0d", result.pair_mass);
                errors++;
            end
            else
            begin
                exp_r = expected_masses.pop_front();
                if (result.pair_mass !== exp_r.pair_mass)
                begin
                    $error("pair_mass expected %0d actual %0d", exp_r.pair_mass,
                        result.pair_mass);
                    errors++;
                end
                if (result.clamped !== exp_r.clamped)
                begin
                    $error("clamped expected %0d actual %0d", exp_r.clamped,
                        result.clamped);
                    errors++;
                end
                if (exp_r.clamped)
                    clamp_seen++;
                words_checked++;
            end
        end
    end

    // extremes of every field and the clamp and zero cases
    task automatic test_directed();
        pim_pkg::pair_t p;
        p = '0;
        send_pair(p);
        p.mass_a = '1; p.mass_b = '1;
        send_pair(p);
        p.px_a = {1'b1, 23'd0}; p.py_a = {1'b1, 23'd0}; p.pz_a = {1'b1, 23'd0};
        p.px_b = {1'b1, 23'd0}; p.py_b = {1'b1, 23'd0}; p.pz_b = {1'b1, 23'd0};
        send_pair(p);
        p.px_a = {1'b0, {23{1'b1}}}; p.py_a = {1'b0, {23{1'b1}}};
        p.pz_a = {1'b0, {23{1'b1}}};
        p.px_b = {1'b0, {23{1'b1}}}; p.py_b = {1'b0, {23{1'b1}}};
        p.pz_b = {1'b0, {23{1'b1}}};
        send_pair(p);
        p.mass_a = '0; p.mass_b = '0;
        send_pair(p);
        // collinear massless: exact zero difference
        p = '0; p.px_a = 24'sd1000; p.px_b = 24'sd2000;
        send_pair(p);
        // opposite momenta, massive
        p = '0; p.mass_a = 23'd938; p.mass_b = 23'd938; p.pz_a = 24'sd5000; p.pz_b = -24'sd5000;
        send_pair(p);
        p.px_a = -24'sd1; p.px_b = 24'sd1;
        send_pair(p);
        // collinear massless with non square energies: rounding clamp
        for (int i = 0; i < 12; i++)
        begin
            p = '0;
            p.px_a = pim_pkg::COMP_W'($urandom_range(1, 4000));
            p.py_a = pim_pkg::COMP_W'($urandom_range(1, 4000));
            p.px_b = pim_pkg::COMP_W'(p.px_a * 3); p.py_b = pim_pkg::COMP_W'(p.py_a * 3);
            p.pz_a = 24'sd1; p.pz_b = 24'sd3;
            send_pair(p);
        end
        drain_all();
    endtask

    // random pairs: full range and small or near-collinear values
    task automatic test_random(input int count);
        pim_pkg::pair_t p;
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 3);
            p = random_pair();
            if (k == 1)
            begin
                p.mass_a = pim_pkg::MASS_W'($urandom_range(0, 2000));
                p.mass_b = pim_pkg::MASS_W'($urandom_range(0, 2000));
                p.px_a = narrow(12); p.py_a = narrow(12); p.pz_a = narrow(12);
                p.px_b = narrow(12); p.py_b = narrow(12); p.pz_b = narrow(12);
            end
            else if (k == 2)
            begin
                p.mass_a = pim_pkg::MASS_W'($urandom_range(0, 3));
                p.mass_b = pim_pkg::MASS_W'($urandom_range(0, 3));
                p.px_b = p.px_a >>> 2; p.py_b = p.py_a >>> 2; p.pz_b = p.pz_a >>> 2;
            end
            send_pair(p);
        end
    endtask

    // receiver held off long while sender keeps offering
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        fork
            begin
                repeat (3 * LATENCY) @(posedge clk);
                hold_receiver = 1'b0;
            end
            test_random(2 * LATENCY);
        join
        drain_all();
    endtask

    task automatic test_full_rate();
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        test_random(150);
        drain_all();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(560);
        drain_all();
        test_backpressure();
        test_full_rate();
        $display("covered %0d pair words, %0d results checked, %0d clamped",
            words_sent, words_checked, clamp_seen);
        $display("including receiver hold-off and a full-rate stretch without idling");
        if (errors == 0 && expected_masses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // timeout
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
